/* hw/rtl/scfla_pkg.sv */
// ----------------------------------------------------------------------------
// Size-class allocator package
// Shared widths, pool geometry, operation and status codes, and the command
// record that travels from the classifier through the queue to the engine.
// ----------------------------------------------------------------------------
package scfla_pkg;

    // Pool geometry: the 19-bit address space spans the whole pool.
    localparam int NUM_SLABS    = 8;
    localparam int SLAB_SIZE    = 65536;
    localparam int CLASS_COUNT  = 12;
    localparam int HEADER_BYTES = 16;

    localparam int ADDR_W     = 19;
    localparam int SLAB_BITS  = 16;
    localparam int SLAB_IDX_W = ADDR_W - SLAB_BITS;
    localparam int SLABS_W    = 4;
    localparam int CLASS_W    = 4;
    localparam int REM_W      = 12;
    localparam int REQ_W      = 20;
    localparam int USIZE_W    = 16;
    localparam int LINK_AW    = ADDR_W - 4;
    localparam int LINK_DEPTH = 1 << LINK_AW;

    localparam logic [REQ_W-1:0] MAX_CLASS_BYTES =
        REQ_W'(HEADER_BYTES << (CLASS_COUNT - 1));

    // Chunks in one slab for each class: slab size over (header + class size).
    localparam logic [REM_W-1:0] CARVE_COUNT [CLASS_COUNT] = '{
        REM_W'(SLAB_SIZE / (HEADER_BYTES + (HEADER_BYTES << 0))),
        REM_W'(SLAB_SIZE / (HEADER_BYTES + (HEADER_BYTES << 1))),
        REM_W'(SLAB_SIZE / (HEADER_BYTES + (HEADER_BYTES << 2))),
        REM_W'(SLAB_SIZE / (HEADER_BYTES + (HEADER_BYTES << 3))),
        REM_W'(SLAB_SIZE / (HEADER_BYTES + (HEADER_BYTES << 4))),
        REM_W'(SLAB_SIZE / (HEADER_BYTES + (HEADER_BYTES << 5))),
        REM_W'(SLAB_SIZE / (HEADER_BYTES + (HEADER_BYTES << 6))),
        REM_W'(SLAB_SIZE / (HEADER_BYTES + (HEADER_BYTES << 7))),
        REM_W'(SLAB_SIZE / (HEADER_BYTES + (HEADER_BYTES << 8))),
        REM_W'(SLAB_SIZE / (HEADER_BYTES + (HEADER_BYTES << 9))),
        REM_W'(SLAB_SIZE / (HEADER_BYTES + (HEADER_BYTES << 10))),
        REM_W'(SLAB_SIZE / (HEADER_BYTES + (HEADER_BYTES << 11)))
    };

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_MEMORY = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [CLASS_W-1:0] cls;
        logic               too_large;
        logic               addr_null;
        logic [ADDR_W-1:0]  addr;
    } cmd_t;

    typedef enum logic {
        BK_EXEC,
        BK_POP
    } back_state_t;

    function automatic logic [USIZE_W-1:0] class_bytes(input logic [CLASS_W-1:0] c);
        class_bytes = USIZE_W'(HEADER_BYTES) << c;
    endfunction

endpackage

/* hw/rtl/scfla_front.sv */
// ----------------------------------------------------------------------------
// Request classifier
// Accepts a request and turns it into a command: picks the size class of an
// allocate, flags oversize requests and null addresses.
// ----------------------------------------------------------------------------
module scfla_front (
    input  logic                        start,
    input  logic                        queue_full,
    input  logic [1:0]                  opcode,
    input  logic [scfla_pkg::REQ_W-1:0] request_size,
    input  logic [scfla_pkg::ADDR_W-1:0] chunk_address,
    output logic                        push,
    output scfla_pkg::cmd_t             cmd
);
    import scfla_pkg::*;

    logic [CLASS_COUNT-1:0] fits;
    logic [CLASS_W-1:0]     cls;

    // A size of zero fits the smallest class just as a size of one does.
    always_comb
    begin
        for (int c = 0; c < CLASS_COUNT; c++)
        begin
            fits[c] = (request_size <= (REQ_W'(HEADER_BYTES) << c));
        end
        cls = CLASS_W'(CLASS_COUNT - 1);
        for (int c = CLASS_COUNT - 2; c >= 0; c--)
        begin
            if (fits[c])
            begin
                cls = CLASS_W'(c);
            end
        end
    end

    assign push          = start && !queue_full;
    assign cmd.op        = opcode;
    assign cmd.cls       = cls;
    assign cmd.too_large = (request_size > MAX_CLASS_BYTES);
    assign cmd.addr_null = (chunk_address == '0);
    assign cmd.addr      = chunk_address;

endmodule

/* hw/rtl/scfla_queue.sv */
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue between the classifier and the allocation engine.
// ----------------------------------------------------------------------------
module scfla_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  scfla_pkg::cmd_t push_cmd,
    input  logic            pop,
    output logic            full,
    output logic            valid,
    output scfla_pkg::cmd_t head_cmd
);
    import scfla_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign head_cmd = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* hw/rtl/scfla_back.sv */
// ----------------------------------------------------------------------------
// Allocation engine
// Executes one command at a time: pops the class free list through the link
// memory, carves fresh chunks from slabs, pushes freed chunks and answers
// size queries. Each result is registered and strobed for one cycle.
// ----------------------------------------------------------------------------
module scfla_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  scfla_pkg::cmd_t               cmd,
    output logic                          cmd_pop,
    output logic                          done,
    output logic [scfla_pkg::ADDR_W-1:0]  result_address,
    output logic [scfla_pkg::USIZE_W-1:0] usable_size,
    output logic [1:0]                    status
);
    import scfla_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;

    logic [ADDR_W-1:0]     free_head_reg  [CLASS_COUNT];
    logic [REM_W-1:0]      carve_rem_reg  [CLASS_COUNT];
    logic [SLAB_IDX_W-1:0] carve_slab_reg [CLASS_COUNT];
    logic [CLASS_W-1:0]    slab_class_reg [NUM_SLABS];
    logic [SLABS_W-1:0]    slabs_used_reg;

    logic [ADDR_W-1:0] link_mem [LINK_DEPTH];
    logic [ADDR_W-1:0] link_rd_data_reg;

    logic                  done_reg;
    logic                  done_next;
    logic [ADDR_W-1:0]     result_address_reg;
    logic [ADDR_W-1:0]     result_address_next;
    logic [USIZE_W-1:0]    usable_size_reg;
    logic [USIZE_W-1:0]    usable_size_next;
    logic [1:0]            status_reg;
    logic [1:0]            status_next;

    // Write ports of the per-class tables and the link memory.
    logic                  head_we;
    logic [CLASS_W-1:0]    head_idx;
    logic [ADDR_W-1:0]     head_wr_data;
    logic                  carve_we;
    logic [REM_W-1:0]      carve_rem_wr;
    logic [SLAB_IDX_W-1:0] carve_slab_wr;
    logic                  claim_we;
    logic                  link_we;
    logic                  link_re;

    // Lookups for the command at the queue head.
    logic [ADDR_W-1:0]     head;
    logic [REM_W-1:0]      rem;
    logic [SLAB_IDX_W-1:0] addr_slab;
    logic                  owned;
    logic [CLASS_W-1:0]    owner_cls;
    logic                  need_slab;
    logic                  pool_empty;
    logic [SLAB_IDX_W-1:0] cur_slab;
    logic [REM_W-1:0]      rem_new;
    logic [26:0]           offset_wide;
    logic [ADDR_W-1:0]     carve_addr;

    assign head       = free_head_reg[cmd.cls];
    assign rem        = carve_rem_reg[cmd.cls];
    assign addr_slab  = cmd.addr[ADDR_W-1:SLAB_BITS];
    assign owned      = !cmd.addr_null && ({1'b0, addr_slab} < slabs_used_reg);
    assign owner_cls  = slab_class_reg[addr_slab];
    assign need_slab  = (rem == '0);
    assign pool_empty = (slabs_used_reg >= SLABS_W'(NUM_SLABS));
    assign cur_slab   = need_slab ? slabs_used_reg[SLAB_IDX_W-1:0] : carve_slab_reg[cmd.cls];
    assign rem_new    = (need_slab ? CARVE_COUNT[cmd.cls] : rem) - REM_W'(1);

    // Offset of a chunk is k * (16 + (16 << c)) + 16, built from two shifts.
    assign offset_wide = (27'(rem_new) << 4) + ((27'(rem_new) << cmd.cls) << 4)
                         + 27'(HEADER_BYTES);
    assign carve_addr  = {cur_slab, offset_wide[SLAB_BITS-1:0]};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_EXEC:
            begin
                if (cmd_valid && cmd.op == OP_ALLOC && !cmd.too_large && head != '0)
                begin
                    state_next = BK_POP;
                end
            end
            BK_POP:
            begin
                state_next = BK_EXEC;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop             = 1'b0;
        done_next           = 1'b0;
        result_address_next = '0;
        usable_size_next    = '0;
        status_next         = ST_OK;
        head_we             = 1'b0;
        head_idx            = cmd.cls;
        head_wr_data        = link_rd_data_reg;
        carve_we            = 1'b0;
        carve_rem_wr        = rem_new;
        carve_slab_wr       = cur_slab;
        claim_we            = 1'b0;
        link_we             = 1'b0;
        link_re             = 1'b0;
        unique case (state_reg)
            BK_EXEC:
            begin
                if (cmd_valid)
                begin
                    cmd_pop   = 1'b1;
                    done_next = 1'b1;
                    unique case (cmd.op)
                        OP_ALLOC:
                        begin
                            if (cmd.too_large)
                            begin
                                status_next = ST_TOO_LARGE;
                            end
                            else if (head != '0)
                            begin
                                // The next link is read from the link memory into a register for BK_POP.
                                cmd_pop   = 1'b0;
                                done_next = 1'b0;
                                link_re   = 1'b1;
                            end
                            else if (need_slab && pool_empty)
                            begin
                                status_next = ST_NO_MEMORY;
                            end
                            else
                            begin
                                carve_we            = 1'b1;
                                claim_we            = need_slab;
                                result_address_next = carve_addr;
                                usable_size_next    = class_bytes(cmd.cls);
                            end
                        end
                        OP_FREE:
                        begin
                            head_idx     = owner_cls;
                            head_wr_data = cmd.addr;
                            head_we      = owned;
                            link_we      = owned;
                        end
                        OP_QUERY:
                        begin
                            usable_size_next = owned ? class_bytes(owner_cls) : '0;
                        end
                        OP_NOP:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            BK_POP:
            begin
                cmd_pop             = 1'b1;
                done_next           = 1'b1;
                head_we             = 1'b1;
                result_address_next = head;
                usable_size_next    = class_bytes(cmd.cls);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_EXEC;
            done_reg       <= 1'b0;
            slabs_used_reg <= '0;
            for (int c = 0; c < CLASS_COUNT; c++)
            begin
                free_head_reg[c]  <= '0;
                carve_rem_reg[c]  <= '0;
                carve_slab_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (head_we)
            begin
                free_head_reg[head_idx] <= head_wr_data;
            end
            if (carve_we)
            begin
                carve_rem_reg[cmd.cls]  <= carve_rem_wr;
                carve_slab_reg[cmd.cls] <= carve_slab_wr;
            end
            if (claim_we)
            begin
                slabs_used_reg <= slabs_used_reg + SLABS_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_address_reg <= result_address_next;
        usable_size_reg    <= usable_size_next;
        status_reg         <= status_next;
        if (claim_we)
        begin
            slab_class_reg[slabs_used_reg[SLAB_IDX_W-1:0]] <= cmd.cls;
        end
    end

    // Link memory: one write port for frees, one registered read for pops.
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[cmd.addr[ADDR_W-1:4]] <= free_head_reg[owner_cls];
        end
        if (link_re)
        begin
            link_rd_data_reg <= link_mem[head[ADDR_W-1:4]];
        end
    end

    assign done           = done_reg;
    assign result_address = result_address_reg;
    assign usable_size    = usable_size_reg;
    assign status         = status_reg;

endmodule

/* hw/rtl/size_class_free_list_allocator_unit.sv */
// ----------------------------------------------------------------------------
// Size-class free-list allocator
//
//   Channel   Handshake        Payload
//   --------  ---------------  ----------------------------------------------
//   request   start / busy     opcode, request_size, chunk_address
//   result    done (strobe)    result_address, usable_size, status
//
// A request is taken when start is high and busy is low; it is classified
// and queued, and done rises after the engine pops it and registers its
// result. The engine takes one request at a time; an allocate served from
// a free list also passes through BK_POP for the registered read of the
// link memory. busy rises only while the two-entry queue is full. Reset
// is asynchronous and leaves every free list empty and no slab claimed;
// the link memory is not cleared. Results are never held off or stalled.
// ----------------------------------------------------------------------------
module size_class_free_list_allocator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    opcode,
    input  logic [scfla_pkg::REQ_W-1:0]   request_size,
    input  logic [scfla_pkg::ADDR_W-1:0]  chunk_address,
    output logic                          done,
    output logic [scfla_pkg::ADDR_W-1:0]  result_address,
    output logic [scfla_pkg::USIZE_W-1:0] usable_size,
    output logic [1:0]                    status
);
    import scfla_pkg::*;

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    cmd_t push_cmd;
    cmd_t head_cmd;

    scfla_front u_front (
        .start         (start),
        .queue_full    (q_full),
        .opcode        (opcode),
        .request_size  (request_size),
        .chunk_address (chunk_address),
        .push          (q_push),
        .cmd           (push_cmd)
    );

    scfla_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .valid    (q_valid),
        .head_cmd (head_cmd)
    );

    scfla_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (q_valid),
        .cmd            (head_cmd),
        .cmd_pop        (q_pop),
        .done           (done),
        .result_address (result_address),
        .usable_size    (usable_size),
        .status         (status)
    );

    assign busy = q_full;

endmodule
